FILE: src/wide_float_add_sub_mul_top_macros.svh
// Assertion macros shared by the wide float lane modules.
`ifndef WIDE_FLOAT_ADD_SUB_MUL_TOP_MACROS_SVH
`define WIDE_FLOAT_ADD_SUB_MUL_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define WF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define WF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: src/wfasm_pkg.sv
// Package with the item types and codes of the wide float lane.
package wfasm_pkg;
    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam int DEPTH = 4;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               a_sign;
        logic signed [63:0] a_exp;
        logic [62:0]        a_mant;
        logic               b_sign;
        logic signed [63:0] b_exp;
        logic [62:0]        b_mant;
    } in_item_t;

    typedef struct packed {
        logic               r_sign;
        logic signed [63:0] r_exp;
        logic [62:0]        r_mant;
    } out_item_t;

    function automatic logic [6:0] clz64(input logic [63:0] v);
        logic [6:0] n;
        logic       found;
        n = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (v[i] && !found) begin
                n = 7'(63 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction
endpackage

FILE: src/wfasm_mul.sv
// Multiply path: partial products, summed product and normalisation.
module wfasm_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  wfasm_pkg::in_item_t   in_item,
    output logic                  out_valid,
    output wfasm_pkg::out_item_t  out_item
);
    import wfasm_pkg::*;

    logic        v1_reg, v2_reg, v3_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic        s1_reg, s2_reg;
    logic [63:0] e1_reg, e2_reg;
    logic [125:0] prod_reg;
    logic [125:0] prod_next;
    logic [63:0]  top;
    out_item_t    res_reg, res_next;

    always_comb
    begin
        prod_next = {62'd0, p00_reg} + {30'd0, p01_reg, 32'd0} + {30'd0, p10_reg, 32'd0}
                  + {p11_reg[61:0], 64'd0};
        top = prod_reg[125:62];
        res_next.r_sign = s2_reg;
        if (top[63]) begin
            res_next.r_mant = top[63:1];
            res_next.r_exp  = e2_reg + 64'd1;
        end else begin
            res_next.r_mant = top[62:0];
            res_next.r_exp  = e2_reg;
        end
        if (res_next.r_mant == 63'd0) begin
            res_next.r_exp = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p00_reg <= {32'd0, in_item.a_mant[31:0]} * {32'd0, in_item.b_mant[31:0]};
        p01_reg <= {32'd0, in_item.a_mant[31:0]} * {33'd0, in_item.b_mant[62:32]};
        p10_reg <= {33'd0, in_item.a_mant[62:32]} * {32'd0, in_item.b_mant[31:0]};
        p11_reg <= {33'd0, in_item.a_mant[62:32]} * {33'd0, in_item.b_mant[62:32]};
        s1_reg  <= in_item.a_sign ^ in_item.b_sign;
        e1_reg  <= in_item.a_exp + in_item.b_exp;
        prod_reg <= prod_next;
        s2_reg  <= s1_reg;
        e2_reg  <= e1_reg;
        res_reg <= res_next;
    end

    assign out_valid = v3_reg;
    assign out_item  = res_reg;
endmodule

FILE: src/wfasm_add.sv
// Add path: swap and align, sum or difference, then renormalisation.
module wfasm_add (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  wfasm_pkg::in_item_t   in_item,
    output logic                  out_valid,
    output wfasm_pkg::out_item_t  out_item
);
    import wfasm_pkg::*;

    `include "wide_float_add_sub_mul_top_macros.svh"

    logic        v1_reg, v2_reg, v3_reg;
    logic        sa_next, sb_next, sb_eff;
    logic [63:0] ea_next, eb_next, d;
    logic [62:0] ma_next, mb_next;
    logic        sa_reg, like_reg;
    logic [63:0] ea_reg;
    logic [63:0] ma_reg, mb_reg;
    logic [63:0] sum_next;
    logic        neg_next;
    logic        rs2_reg, like2_reg;
    logic [63:0] e2_reg, val2_reg;
    logic [6:0]  lz;
    out_item_t   res_next, res_reg;

    always_comb
    begin
        sb_eff = in_item.b_sign ^ (in_item.cmd == CMD_SUB);
        if ($signed(in_item.a_exp) < $signed(in_item.b_exp)) begin
            sa_next = sb_eff;          sb_next = in_item.a_sign;
            ea_next = in_item.b_exp;   eb_next = in_item.a_exp;
            ma_next = in_item.b_mant;  mb_next = in_item.a_mant;
        end else begin
            sa_next = in_item.a_sign;  sb_next = sb_eff;
            ea_next = in_item.a_exp;   eb_next = in_item.b_exp;
            ma_next = in_item.a_mant;  mb_next = in_item.b_mant;
        end
        d = ea_next - eb_next;
    end

    always_comb
    begin
        if (like_reg) begin
            sum_next = ma_reg + mb_reg;
        end else begin
            sum_next = ma_reg - mb_reg;
        end
        neg_next = !like_reg && sum_next[63];
    end

    always_comb
    begin
        lz = clz64(val2_reg);
        res_next.r_sign = rs2_reg;
        if (like2_reg) begin
            if (val2_reg[63]) begin
                res_next.r_mant = val2_reg[63:1];
                res_next.r_exp  = e2_reg + 64'd1;
            end else begin
                res_next.r_mant = val2_reg[62:0];
                res_next.r_exp  = e2_reg;
            end
        end else if (val2_reg == 64'd0) begin
            res_next.r_mant = 63'd0;
            res_next.r_exp  = 64'd0;
        end else begin
            res_next.r_mant = 63'(val2_reg << (lz - 7'd1));
            res_next.r_exp  = e2_reg - {57'd0, lz - 7'd1};
        end
        if (res_next.r_mant == 63'd0) begin
            res_next.r_exp = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg   <= sa_next;
        like_reg <= (sa_next == sb_next);
        ea_reg   <= ea_next;
        ma_reg   <= {1'b0, ma_next};
        mb_reg   <= (d >= 64'd64) ? 64'd0 : ({1'b0, mb_next} >> d[5:0]);
        rs2_reg  <= sa_reg ^ neg_next;
        like2_reg <= like_reg;
        e2_reg   <= ea_reg;
        val2_reg <= neg_next ? (64'd0 - sum_next) : sum_next;
        res_reg  <= res_next;
    end

    assign out_valid = v3_reg;
    assign out_item  = res_reg;

    `WF_ASSERT_IMP(zero_exp_a, clk, rst_n, v3_reg && res_reg.r_mant == 63'd0,
        res_reg.r_exp == 64'd0)
    `WF_ASSERT_NEXT(valid_flow_a, clk, rst_n, v1_reg, v2_reg)
    `WF_ASSERT_IMP(norm_a, clk, rst_n, v3_reg && !$past(like2_reg) && $past(val2_reg) != 64'd0,
        res_reg.r_mant[62])
endmodule

FILE: src/wide_float_add_sub_mul_top.sv
// Top level of the wide float lane: add and multiply paths and result select.
// Items pass three path stages and the output stage; one item accepted every cycle.
// busy is always low, so throughput is one item per cycle.
// The three stage add and multiply paths run side by side, then one output stage.
// Reset clears all valid bits asynchronously; payload registers are not reset.
module wide_float_add_sub_mul_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  wfasm_pkg::in_item_t   in_item,
    output logic                  strobe,
    output wfasm_pkg::out_item_t  out_item
);
    import wfasm_pkg::*;

    `include "wide_float_add_sub_mul_top_macros.svh"

    logic      take;
    logic      add_v, mul_v;
    out_item_t add_r, mul_r;
    logic [DEPTH-2:0] sel_reg;
    logic      strobe_reg;
    out_item_t out_reg;

    assign busy = 1'b0;
    assign take = start && !busy;

    wfasm_add u_add (.clk(clk), .rst_n(rst_n), .in_valid(take && !in_item.cmd[1]),
        .in_item(in_item), .out_valid(add_v), .out_item(add_r));
    wfasm_mul u_mul (.clk(clk), .rst_n(rst_n), .in_valid(take && in_item.cmd[1]),
        .in_item(in_item), .out_valid(mul_v), .out_item(mul_r));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sel_reg    <= '0;
            strobe_reg <= 1'b0;
        end else begin
            sel_reg    <= {sel_reg[DEPTH-3:0], in_item.cmd[1]};
            strobe_reg <= add_v || mul_v;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= sel_reg[DEPTH-2] ? mul_r : add_r;
    end

    assign strobe   = strobe_reg;
    assign out_item = out_reg;

    `WF_ASSERT_IMP(one_path, clk, rst_n, 1'b1, !(add_v && mul_v))
    `WF_ASSERT_IMP(sel_match, clk, rst_n, add_v || mul_v, sel_reg[DEPTH-2] == mul_v)
    `WF_ASSERT_NEXT(strobe_follows, clk, rst_n, add_v || mul_v, strobe)
endmodule
